FILE: rtl/imdu_pkg.sv
// Shared types and constants of the 128-bit multiply/divide unit.
// No dependencies.
package imdu_pkg;

   localparam int FUNC_BITS = 3;
   localparam int HALF_BITS = 64;

   localparam logic [FUNC_BITS-1:0] FUNC_MUL  = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DIVU = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_REMU = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_DIVS = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_REMS = 3'd4;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic                 a_neg;
      logic                 b_neg;
      logic                 b_zero;
   } ctl_type;

endpackage

FILE: rtl/imdu_req_if.sv
// Request channel of the multiply/divide unit.
// Depends on imdu_pkg.
interface imdu_req_if import imdu_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [HALF_BITS-1:0] a_hi;
   logic [HALF_BITS-1:0] a_lo;
   logic [HALF_BITS-1:0] b_hi;
   logic [HALF_BITS-1:0] b_lo;
   modport source (output valid, func, a_hi, a_lo, b_hi, b_lo, input ready);
   modport sink (input valid, func, a_hi, a_lo, b_hi, b_lo, output ready);
endinterface

FILE: rtl/imdu_rsp_if.sv
// Response channel of the multiply/divide unit.
// Depends on imdu_pkg.
interface imdu_rsp_if import imdu_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [HALF_BITS-1:0] result_hi;
   logic [HALF_BITS-1:0] result_lo;
   logic                 div_by_zero;
   modport source (output valid, result_hi, result_lo, div_by_zero, input ready);
   modport sink (input valid, result_hi, result_lo, div_by_zero, output ready);
endinterface

FILE: rtl/int128_mul_div_unit_top.sv
// Each request passes through the prepare register, which loads at the accepting edge, then one
// cell per operand bit, then the output register, before its response is valid.
// Throughput: one request per cycle; the whole chain holds while a response waits.
// Synchronous active-high reset clears all valid flags.
// Depends on imdu_pkg, imdu_req_if, imdu_rsp_if and imdu_cell.
module int128_mul_div_unit_top import imdu_pkg::*; #(
   parameter int OPERAND_BITS = 128
) (
   input logic       clock,
   input logic       reset,
   imdu_req_if.sink  req,
   imdu_rsp_if.source rsp
);

   localparam int W = OPERAND_BITS;

   logic         enable;
   logic         v_chain [W+1];
   ctl_type      c_chain [W+1];
   logic [W-1:0] x_chain [W+1];
   logic [W-1:0] y_chain [W+1];
   logic [W-1:0] z_chain [W+1];

   logic         prep_valid_ff;
   ctl_type      prep_ctl_ff, prep_ctl_in;
   logic [W-1:0] prep_x_ff, prep_y_ff, prep_x_in, prep_y_in;
   logic [W-1:0] a_op, b_op;
   logic         signed_op;

   logic         rsp_valid_ff;
   logic [2*HALF_BITS-1:0] result_ff, result_in;
   logic         dbz_ff, dbz_in;
   logic [W-1:0] res_w;
   ctl_type      last_ctl;

   assign enable    = ~rsp_valid_ff | rsp.ready;
   assign req.ready = enable;

   always_comb begin
      a_op      = W'({req.a_hi, req.a_lo});
      b_op      = W'({req.b_hi, req.b_lo});
      signed_op = (req.func == FUNC_DIVS) || (req.func == FUNC_REMS);
      prep_ctl_in.func   = req.func;
      prep_ctl_in.a_neg  = signed_op & a_op[W-1];
      prep_ctl_in.b_neg  = signed_op & b_op[W-1];
      prep_ctl_in.b_zero = (b_op == '0);
      prep_x_in = prep_ctl_in.a_neg ? -a_op : a_op;
      prep_y_in = prep_ctl_in.b_neg ? -b_op : b_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (enable) begin
         prep_valid_ff <= req.valid;
      end
      if (enable) begin
         prep_ctl_ff <= prep_ctl_in;
         prep_x_ff   <= prep_x_in;
         prep_y_ff   <= prep_y_in;
      end
   end

   assign v_chain[0] = prep_valid_ff;
   assign c_chain[0] = prep_ctl_ff;
   assign x_chain[0] = prep_x_ff;
   assign y_chain[0] = prep_y_ff;
   assign z_chain[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      imdu_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (v_chain[i]),
         .in_ctl    (c_chain[i]),
         .in_x      (x_chain[i]),
         .in_y      (y_chain[i]),
         .in_z      (z_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_ctl   (c_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_y     (y_chain[i+1]),
         .out_z     (z_chain[i+1])
      );
   end

   always_comb begin
      last_ctl = c_chain[W];
      dbz_in   = 1'b0;
      unique case (last_ctl.func)
         FUNC_MUL:  res_w = z_chain[W];
         FUNC_DIVU: res_w = x_chain[W];
         FUNC_REMU: res_w = z_chain[W];
         FUNC_DIVS: res_w = (last_ctl.a_neg ^ last_ctl.b_neg) ? -x_chain[W] : x_chain[W];
         FUNC_REMS: res_w = last_ctl.a_neg ? -z_chain[W] : z_chain[W];
         default:   res_w = '0;
      endcase
      if (last_ctl.func != FUNC_MUL && last_ctl.b_zero) begin
         if (last_ctl.func <= FUNC_REMS) begin
            dbz_in = 1'b1;
         end
         res_w = '0;
      end
      result_in = (2*HALF_BITS)'(res_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= v_chain[W];
      end
      if (enable) begin
         result_ff <= result_in;
         dbz_ff    <= dbz_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_hi   = result_ff[2*HALF_BITS-1:HALF_BITS];
   assign rsp.result_lo   = result_ff[HALF_BITS-1:0];
   assign rsp.div_by_zero = dbz_ff;

endmodule

FILE: rtl/imdu_cell.sv
// One step cell: a restoring divide step or a shift-add multiply step.
// Depends on imdu_pkg.
module imdu_cell import imdu_pkg::*; #(
   parameter int W = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  ctl_type      in_ctl,
   input  logic [W-1:0] in_x,
   input  logic [W-1:0] in_y,
   input  logic [W-1:0] in_z,
   output logic         out_valid,
   output ctl_type      out_ctl,
   output logic [W-1:0] out_x,
   output logic [W-1:0] out_y,
   output logic [W-1:0] out_z
);

   logic         valid_ff;
   ctl_type      ctl_ff;
   logic [W-1:0] x_ff, y_ff, z_ff;
   logic [W-1:0] x_in, y_in, z_in;
   logic [W-1:0] shifted;
   logic [W:0]   diff;
   logic         take;

   always_comb begin
      shifted = {in_z[W-2:0], in_x[W-1]};
      diff    = {in_z[W-1], shifted} - {1'b0, in_y};
      take    = in_z[W-1] | ~diff[W];
      if (in_ctl.func == FUNC_MUL) begin
         z_in = in_y[0] ? in_z + in_x : in_z;
         x_in = {in_x[W-2:0], 1'b0};
         y_in = {1'b0, in_y[W-1:1]};
      end else begin
         z_in = take ? diff[W-1:0] : shifted;
         x_in = {in_x[W-2:0], take};
         y_in = in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         ctl_ff <= in_ctl;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule
